### sv/prs_pkg.sv
// Shared types and constants of the 48 kHz to 16 kHz polyphase resampler.
// No dependencies; used by the channel interfaces and all modules.
package prs_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CIDX_W     = 10;
  localparam int CVAL_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int SKIP_W     = 9;
  localparam int COEF_FRAC  = 16;

  // Interpolation and decimation rates of the three stages.
  localparam int UP_INT   = 4;
  localparam int UP_DEC   = 3;
  localparam int DOWN_DEC = 2;

  localparam logic [CFG_IDX_W-1:0] REG_UP_LAST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_LAST = 2'd1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;
  localparam logic TABLE_UP   = 1'b0;
  localparam logic TABLE_DOWN = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } out_res_t;

endpackage

### sv/prs_if.sv
// Valid/ready channel interfaces of the resampler: input, result, configuration.
// Depends on prs_pkg for field widths.
interface prs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic signed [prs_pkg::SAMPLE_W-1:0]  sample_in;
  logic                                 coef_table;
  logic        [prs_pkg::CIDX_W-1:0]    coef_index;
  logic signed [prs_pkg::CVAL_W-1:0]    coef_value;
  modport source (output valid, command, sample_in, coef_table, coef_index, coef_value,
                  input ready);
  modport sink (input valid, command, sample_in, coef_table, coef_index, coef_value,
                output ready);
endinterface

interface prs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [prs_pkg::SAMPLE_W-1:0]  sample_out;
  logic                                 clipped;
  modport source (output valid, sample_out, clipped, input ready);
  modport sink (input valid, sample_out, clipped, output ready);
endinterface

interface prs_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [prs_pkg::CFG_IDX_W-1:0]      index;
  logic [prs_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/polyphase_resampler_48k_to_16k_unit.sv
// Three-stage polyphase resampler (3-to-4 up, two 2-to-1 down) on one shared MAC.
// A sample is sequenced through the stages with one multiply-accumulate per tap: up to two
// hits of the 3-to-4 filter (last/4+1 taps each) and up to two of the 2-to-1 filters (last+1
// taps each), and is held longer while a result waits for the output register. One item at a time.
// After reset the history rings are cleared while the input is held off.
module polyphase_resampler_48k_to_16k_unit #(
  parameter int RING_DEPTH     = 512,
  parameter int COEF_WIDTH     = 20,
  parameter int HIST_FRAC_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  prs_in_if.sink    in_ch,
  prs_out_if.source out_ch,
  prs_cfg_if.sink   cfg_ch
);

  localparam int HW    = 16 + HIST_FRAC_BITS;
  localparam int CW    = COEF_WIDTH;
  localparam int RAW   = $clog2(RING_DEPTH);
  localparam int CAW   = $clog2(RING_DEPTH + 1);
  localparam int ACCW  = HW + CW + CAW + 1;
  localparam int LTW   = prs_pkg::CIDX_W;
  localparam int KW    = LTW + 1;
  localparam int SW    = prs_pkg::SKIP_W;
  localparam logic [RAW-1:0] RING_LAST = RAW'(RING_DEPTH - 1);

  typedef enum logic [2:0] {
    CLEAR, IDLE, PUSH, PHASE, MAC, SKIP, SAT, EMIT
  } state_t;

  typedef enum logic [1:0] {
    ST_UP, ST_MID, ST_LOW
  } stage_t;

  state_t  state_r;
  stage_t  stage_r;
  logic [1:0]      iter_r;
  logic [RAW-1:0]  clr_r;
  logic [RAW-1:0]  head_r  [3];
  logic [1:0]      phase_r [3];
  logic [SW-1:0]   skip_r  [3];
  logic [LTW-1:0]  up_last_r;
  logic [LTW-1:0]  down_last_r;
  logic [SW-1:0]   delay_up_r;
  logic [SW-1:0]   delay_down_r;
  logic signed [HW-1:0] val_r;

  // MAC pipeline: issue, memory read, product, accumulate.
  logic            issue_r;
  logic [KW-1:0]   k_r;
  logic [KW-1:0]   last_r;
  logic [RAW-1:0]  l_r;
  logic            rd_v_r;
  logic            prod_v_r;
  logic signed [HW-1:0]    h0_q_r, h1_q_r, h2_q_r;
  logic signed [CW-1:0]    cu_q_r, cd_q_r;
  logic signed [HW+CW-1:0] prod_r;
  logic signed [ACCW-1:0]  acc_r;

  logic signed [HW-1:0] hist0 [RING_DEPTH];
  logic signed [HW-1:0] hist1 [RING_DEPTH];
  logic signed [HW-1:0] hist2 [RING_DEPTH];
  logic signed [CW-1:0] coef_up   [RING_DEPTH + 1];
  logic signed [CW-1:0] coef_down [RING_DEPTH + 1];

  logic signed [prs_pkg::SAMPLE_W-1:0] sample_out_r;
  logic                                clipped_r;
  logic                                out_valid_r;

  // Clamped last taps and the filter delays that follow from them.
  logic [LTW-1:0] up_last_c;
  logic [LTW-1:0] down_last_c;
  logic [26:0]    div6_prod;
  logic [LTW-1:0] last_sel;

  always_comb begin
    up_last_c   = (32'(up_last_r) > RING_DEPTH) ? LTW'(RING_DEPTH) : up_last_r;
    down_last_c = (32'(down_last_r) > RING_DEPTH) ? LTW'(RING_DEPTH) : down_last_r;
    // x / 6 as x * 43691 / 2^18, exact for ten-bit x.
    div6_prod   = 27'(up_last_c) * 27'd43691;
    last_sel    = (stage_r == ST_UP) ? up_last_c : down_last_c;
  end

  // Memory write controls.
  logic            in_acc;
  logic            cfg_acc;
  logic [RAW-1:0]  head_dec;
  logic [RAW-1:0]  hist_wa;
  logic signed [HW-1:0] hist_wd;
  logic [2:0]      hist_we;
  logic            coef_ok;
  logic            coef_we_up;
  logic            coef_we_down;
  logic signed [CW-1:0] coef_wd;
  logic [CAW-1:0]  coef_wa;
  logic [CAW-1:0]  coef_ra;

  always_comb begin
    in_acc   = in_ch.valid && in_ch.ready;
    cfg_acc  = cfg_ch.valid && cfg_ch.ready;
    head_dec = (head_r[stage_r] == '0) ? RING_LAST : head_r[stage_r] - RAW'(1);
    hist_wa  = (state_r == CLEAR) ? clr_r : head_dec;
    hist_wd  = (state_r == CLEAR) ? '0 : val_r;
    hist_we[0] = (state_r == CLEAR) || (state_r == PUSH && stage_r == ST_UP);
    hist_we[1] = (state_r == CLEAR) || (state_r == PUSH && stage_r == ST_MID);
    hist_we[2] = (state_r == CLEAR) || (state_r == PUSH && stage_r == ST_LOW);
    coef_ok      = 32'(in_ch.coef_index) < (RING_DEPTH + 1);
    coef_we_up   = in_acc && in_ch.command == prs_pkg::CMD_COEF && coef_ok &&
                   in_ch.coef_table == prs_pkg::TABLE_UP;
    coef_we_down = in_acc && in_ch.command == prs_pkg::CMD_COEF && coef_ok &&
                   in_ch.coef_table == prs_pkg::TABLE_DOWN;
    coef_wd  = CW'(in_ch.coef_value);
    coef_wa  = CAW'(in_ch.coef_index);
    coef_ra  = CAW'(k_r);
  end

  always_ff @(posedge clk) begin
    if (hist_we[0]) hist0[hist_wa] <= hist_wd;
    if (hist_we[1]) hist1[hist_wa] <= hist_wd;
    if (hist_we[2]) hist2[hist_wa] <= hist_wd;
    if (issue_r) begin
      h0_q_r <= hist0[l_r];
      h1_q_r <= hist1[l_r];
      h2_q_r <= hist2[l_r];
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we_up)   coef_up[coef_wa]   <= coef_wd;
    if (coef_we_down) coef_down[coef_wa] <= coef_wd;
    if (issue_r) begin
      cu_q_r <= coef_up[coef_ra];
      cd_q_r <= coef_down[coef_ra];
    end
  end

  // Shared multiplier and accumulator.
  logic signed [HW-1:0] h_sel;
  logic signed [CW-1:0] c_sel;

  always_comb begin
    case (stage_r)
      ST_UP:   h_sel = h0_q_r;
      ST_MID:  h_sel = h1_q_r;
      default: h_sel = h2_q_r;
    endcase
    c_sel = (stage_r == ST_UP) ? cu_q_r : cd_q_r;
  end

  always_ff @(posedge clk) begin
    prod_r <= h_sel * c_sel;
  end

  logic signed [HW-1:0] shaped_hist;
  prs_pkg::out_res_t    shaped_res;

  prs_shape #(
    .HW   (HW),
    .ACCW (ACCW),
    .FRAC (HIST_FRAC_BITS)
  ) u_shape (
    .acc      (acc_r),
    .hist_val (shaped_hist),
    .res      (shaped_res)
  );

  logic [KW-1:0]  k_step;
  logic [KW-1:0]  k_next;
  logic [KW-1:0]  k_first;
  logic [1:0]     phase_dec;
  logic [SW-1:0]  delay_sel;

  always_comb begin
    k_step    = (stage_r == ST_UP) ? KW'(prs_pkg::UP_INT) : KW'(1);
    k_next    = k_r + k_step;
    k_first   = (stage_r == ST_UP) ? KW'(iter_r) : '0;
    phase_dec = phase_r[stage_r] - 2'd1;
    delay_sel = (stage_r == ST_UP) ? delay_up_r : delay_down_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= CLEAR;
      stage_r      <= ST_UP;
      iter_r       <= '0;
      clr_r        <= '0;
      up_last_r    <= '0;
      down_last_r  <= '0;
      delay_up_r   <= '0;
      delay_down_r <= '0;
      issue_r      <= 1'b0;
      rd_v_r       <= 1'b0;
      prod_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int s = 0; s < 3; s++) begin
        head_r[s]  <= '0;
        phase_r[s] <= 2'd1;
        skip_r[s]  <= '0;
      end
    end else begin
      delay_up_r   <= div6_prod[26:18];
      delay_down_r <= SW'(down_last_c >> 2);
      if (cfg_acc) begin
        if (cfg_ch.index == prs_pkg::REG_UP_LAST) up_last_r <= cfg_ch.data;
        if (cfg_ch.index == prs_pkg::REG_DOWN_LAST) down_last_r <= cfg_ch.data;
      end
      // The emit step reloads the output register itself.
      if (out_ch.ready && state_r != EMIT) out_valid_r <= 1'b0;
      rd_v_r   <= issue_r;
      prod_v_r <= rd_v_r;
      if (prod_v_r) acc_r <= acc_r + ACCW'(prod_r);

      case (state_r)
        CLEAR: begin
          clr_r <= clr_r + RAW'(1);
          if (clr_r == RING_LAST) state_r <= IDLE;
        end
        IDLE: begin
          if (in_acc && in_ch.command == prs_pkg::CMD_SAMPLE) begin
            val_r   <= HW'(in_ch.sample_in) <<< HIST_FRAC_BITS;
            stage_r <= ST_UP;
            iter_r  <= '0;
            state_r <= PUSH;
          end
        end
        PUSH: begin
          head_r[stage_r] <= head_dec;
          state_r         <= PHASE;
        end
        PHASE: begin
          if (phase_dec != 2'd0) begin
            phase_r[stage_r] <= phase_dec;
            if (iter_r == 2'(prs_pkg::UP_INT - 1)) begin
              state_r <= IDLE;
            end else begin
              iter_r  <= iter_r + 2'd1;
              stage_r <= ST_UP;
            end
          end else begin
            phase_r[stage_r] <= (stage_r == ST_UP) ? 2'(prs_pkg::UP_DEC)
                                                   : 2'(prs_pkg::DOWN_DEC);
            k_r     <= k_first;
            last_r  <= KW'(last_sel);
            l_r     <= head_r[stage_r];
            issue_r <= k_first <= KW'(last_sel);
            acc_r   <= '0;
            state_r <= MAC;
          end
        end
        MAC: begin
          if (issue_r) begin
            k_r     <= k_next;
            l_r     <= (l_r == RING_LAST) ? '0 : l_r + RAW'(1);
            issue_r <= k_next <= last_r;
          end else if (!rd_v_r && !prod_v_r) begin
            state_r <= SKIP;
          end
        end
        SKIP: begin
          if (skip_r[stage_r] < delay_sel) begin
            skip_r[stage_r] <= skip_r[stage_r] + SW'(1);
            state_r <= (iter_r == 2'(prs_pkg::UP_INT - 1)) ? IDLE : PHASE;
            iter_r  <= iter_r + 2'd1;
            stage_r <= ST_UP;
          end else begin
            state_r <= SAT;
          end
        end
        SAT: begin
          if (stage_r == ST_LOW) begin
            state_r <= EMIT;
          end else begin
            val_r   <= shaped_hist;
            stage_r <= (stage_r == ST_UP) ? ST_MID : ST_LOW;
            state_r <= PUSH;
          end
        end
        EMIT: begin
          // Wait here only while an earlier beat still sits in the output register.
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            sample_out_r <= shaped_res.sample;
            clipped_r    <= shaped_res.clipped;
            state_r      <= (iter_r == 2'(prs_pkg::UP_INT - 1)) ? IDLE : PHASE;
            iter_r       <= iter_r + 2'd1;
            stage_r      <= ST_UP;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign in_ch.ready       = (state_r == IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = sample_out_r;
  assign out_ch.clipped    = clipped_r;

  // A sample beat starts a busy period.
  a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.command == prs_pkg::CMD_SAMPLE) |=> !in_ch.ready)
    else $error("input ready right after a sample beat");

  // Phase counters never rest at zero.
  a_phase_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r[0] != 2'd0) && (phase_r[1] != 2'd0) && (phase_r[2] != 2'd0))
    else $error("phase counter at zero");

  // A new result appears only from the emit step.
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == EMIT))
    else $error("result raised outside emit");

  // The MAC pipeline is empty once the delay check starts.
  a_mac_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SKIP) |-> (!issue_r && !rd_v_r && !prod_v_r))
    else $error("MAC pipeline busy at delay check");

endmodule

### sv/prs_shape.sv
// Truncation toward zero and saturation of a stage accumulator.
// Gives the history value for the next stage and the final 16-bit result.
// Depends on prs_pkg.
module prs_shape #(
  parameter int HW   = 24,
  parameter int ACCW = 55,
  parameter int FRAC = 8
) (
  input  logic signed [ACCW-1:0] acc,
  output logic signed [HW-1:0]   hist_val,
  output prs_pkg::out_res_t      res
);

  localparam int SH_MID = prs_pkg::COEF_FRAC;
  localparam int SH_FIN = prs_pkg::COEF_FRAC + FRAC;
  localparam logic signed [ACCW-1:0] BIAS_MID = ACCW'((64'd1 << SH_MID) - 64'd1);
  localparam logic signed [ACCW-1:0] BIAS_FIN = ACCW'((64'd1 << SH_FIN) - 64'd1);
  localparam logic signed [ACCW-1:0] HMAX = ACCW'((64'sd1 <<< (HW - 1)) - 64'sd1);
  localparam logic signed [ACCW-1:0] HMIN = -HMAX - ACCW'(1);
  localparam logic signed [ACCW-1:0] OMAX = ACCW'(32767);
  localparam logic signed [ACCW-1:0] OMIN = -OMAX - ACCW'(1);
  localparam logic signed [ACCW-1:0] ZERO = ACCW'(0);

  logic                   neg;
  logic signed [ACCW-1:0] t_mid;
  logic signed [ACCW-1:0] t_fin;

  // Adding 2^sh - 1 to a negative value before the arithmetic shift rounds toward zero.
  always_comb begin
    neg   = acc[ACCW-1];
    t_mid = (acc + (neg ? BIAS_MID : ZERO)) >>> SH_MID;
    t_fin = (acc + (neg ? BIAS_FIN : ZERO)) >>> SH_FIN;
    if (t_mid > HMAX) begin
      hist_val = HMAX[HW-1:0];
    end else if (t_mid < HMIN) begin
      hist_val = HMIN[HW-1:0];
    end else begin
      hist_val = t_mid[HW-1:0];
    end
    if (t_fin > OMAX) begin
      res.sample  = OMAX[prs_pkg::SAMPLE_W-1:0];
      res.clipped = 1'b1;
    end else if (t_fin < OMIN) begin
      res.sample  = OMIN[prs_pkg::SAMPLE_W-1:0];
      res.clipped = 1'b1;
    end else begin
      res.sample  = t_fin[prs_pkg::SAMPLE_W-1:0];
      res.clipped = 1'b0;
    end
  end

endmodule
